// File: src/mpkd_pkg.sv
package mpkd_pkg;

   // sizing of the per-pin state
   localparam int NUM_PINS    = 8;
   localparam int COUNT_WIDTH = 8;
   localparam int PIN_IDX_W   = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

   // field widths of the request and result
   localparam int PIN_W    = 3;
   localparam int TICKS_W  = 8;
   localparam int CMD_W    = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   // request commands
   localparam logic [CMD_W-1:0] CMD_DC       = 2'd0;
   localparam logic [CMD_W-1:0] CMD_AC_EDGE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_AC_END   = 2'd2;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   // per-pin state and request fields seen by the update logic
   typedef struct packed {
      logic              pin_ok;
      logic [CMD_W-1:0]  cmd;
      logic              level;
      logic              polarity;
      logic              prev;
      count_type         cnt;
      count_type         load;
   } step_in_type;

   // per-pin writeback and record controls
   typedef struct packed {
      logic       write_en;
      logic       prev;
      count_type  cnt;
      logic       raised;
      logic       rec_pin_en;
      logic       rec_edge_en;
   } step_out_type;

endpackage

// File: src/mpkd_step.sv
module mpkd_step (
   input  mpkd_pkg::step_in_type  step_i,
   output mpkd_pkg::step_out_type step_o
);
   import mpkd_pkg::*;

   logic      match;
   count_type cnt_dec;

   // edge of the watched polarity
   assign match   = (step_i.level == step_i.polarity) && (step_i.prev != step_i.polarity);
   assign cnt_dec = step_i.cnt - count_type'(1);

   // lockout and edge decisions for one pin
   always_comb begin
      step_o             = '0;
      step_o.cnt         = step_i.cnt;
      step_o.prev        = step_i.prev;
      if (step_i.pin_ok) begin
         unique case (step_i.cmd)
            CMD_DC: begin
               step_o.write_en = 1'b1;
               if (step_i.cnt != '0) begin
                  step_o.cnt = cnt_dec;
               end else begin
                  if (step_i.level != step_i.prev) begin
                     step_o.raised      = 1'b1;
                     step_o.rec_pin_en  = 1'b1;
                     step_o.rec_edge_en = 1'b1;
                     step_o.cnt         = step_i.load;
                  end
                  step_o.prev = step_i.level;
               end
            end
            CMD_AC_EDGE: begin
               step_o.write_en = 1'b1;
               step_o.prev     = step_i.level;
               if (step_i.cnt != '0) begin
                  step_o.cnt = match ? step_i.load : cnt_dec;
               end else if (match) begin
                  step_o.cnt        = step_i.load;
                  step_o.rec_pin_en = 1'b1;
                  step_o.raised     = 1'b1;
               end
            end
            CMD_AC_END: begin
               step_o.write_en = 1'b1;
               step_o.prev     = step_i.level;
               if (step_i.cnt != '0) begin
                  step_o.raised = (cnt_dec == '0);
                  step_o.cnt    = match ? step_i.load : cnt_dec;
               end else if (match) begin
                  step_o.cnt        = step_i.load;
                  step_o.rec_pin_en = 1'b1;
               end
            end
            default: begin
               step_o.write_en = 1'b0;
            end
         endcase
      end
   end

endmodule

// File: src/multi_pin_key_debouncer.sv
// a request's result is registered in the input stage, then in the result register that
// drives rsp, where a stalled rsp holds it
// throughput: one request per cycle unless rsp stalls; the per-pin read-modify-write
// of the lockout counter and remembered level completes in the single update stage
// reset (synchronous, active high): counters, levels and the event record clear,
// lockout_ticks returns to 20, both pipeline stages empty
module multi_pin_key_debouncer (
   input  logic                                 clock,
   input  logic                                 reset,
   // request: tdata = pin_index[2:0], level[3], edge_polarity[4], zero fill
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mpkd_pkg::REQ_DATA_W-1:0]      req_tdata,
   // request: tuser = command[1:0]
   input  logic [mpkd_pkg::CMD_W-1:0]           req_tuser,
   // result: tdata = event_raised[0], event_pin[3:1], event_edge[4], zero fill
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mpkd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // lockout_ticks register
   input  logic                                 csr_we,
   input  logic [mpkd_pkg::TICKS_W-1:0]         csr_wdata
);
   import mpkd_pkg::*;

   logic [TICKS_W-1:0]    lockout_ff;
   logic                  s1_valid_ff;
   logic [PIN_W-1:0]      s1_pin_ff;
   logic                  s1_level_ff;
   logic                  s1_pol_ff;
   logic [CMD_W-1:0]      s1_cmd_ff;
   count_type             count_ff [NUM_PINS];
   logic [NUM_PINS-1:0]   prev_ff;
   logic [PIN_W-1:0]      rec_pin_ff;
   logic                  rec_edge_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [PIN_W-1:0]      rec_pin_in;
   logic                  rec_edge_in;
   logic [PIN_IDX_W-1:0]  s1_idx;
   logic                  advance;
   step_in_type           step_in;
   step_out_type          step_out;

   // handshake: the update stage moves when the result register is empty or being taken
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // lockout register
   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff <= TICKS_W'(20);
      end else if (csr_we) begin
         lockout_ff <= csr_wdata;
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_pin_ff   <= req_tdata[PIN_W-1:0];
         s1_level_ff <= req_tdata[PIN_W];
         s1_pol_ff   <= req_tdata[PIN_W+1];
         s1_cmd_ff   <= req_tuser;
      end
   end

   // per-pin state read
   assign s1_idx = PIN_IDX_W'(s1_pin_ff);

   always_comb begin
      step_in.pin_ok   = (32'(s1_pin_ff) < NUM_PINS);
      step_in.cmd      = s1_cmd_ff;
      step_in.level    = s1_level_ff;
      step_in.polarity = s1_pol_ff;
      step_in.prev     = prev_ff[s1_idx];
      step_in.cnt      = count_ff[s1_idx];
      step_in.load     = count_type'(lockout_ff);
   end

   mpkd_step u_step (
      .step_i (step_in),
      .step_o (step_out)
   );

   // event record after this request
   assign rec_pin_in  = step_out.rec_pin_en  ? s1_pin_ff   : rec_pin_ff;
   assign rec_edge_in = step_out.rec_edge_en ? s1_level_ff : rec_edge_ff;

   // per-pin state and record writeback
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PINS; i++) begin
            count_ff[i] <= '0;
         end
         prev_ff     <= '0;
         rec_pin_ff  <= '0;
         rec_edge_ff <= 1'b0;
      end else if (s1_valid_ff && advance) begin
         if (step_out.write_en) begin
            count_ff[s1_idx] <= step_out.cnt;
            prev_ff[s1_idx]  <= step_out.prev;
         end
         rec_pin_ff  <= rec_pin_in;
         rec_edge_ff <= rec_edge_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_data_ff <= RSP_DATA_W'({rec_edge_in, rec_pin_in, step_out.raised});
      end
   end

   // checks
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance |=> rsp_valid_ff)
      else $error("update stage result lost");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("request stalled with empty input stage");

   a_edge_with_event: assert property (@(posedge clock) disable iff (reset)
      !$stable(rec_edge_ff) |-> rsp_valid_ff && rsp_data_ff[0])
      else $error("record edge changed without a raised event");

endmodule
